### rtl/core/vitc_pkg.sv
//------------------------------------------------------------------------------
// vitc_pkg
// Shared types, constants and helpers for the VITC code word generator.
//------------------------------------------------------------------------------
`default_nettype none

package vitc_pkg;

	localparam int unsigned LINE_W      = 10;
	localparam int unsigned COUNT_W     = 31;
	localparam int unsigned FPS_W       = 5;
	localparam int unsigned DIVD_W      = 32;
	localparam int unsigned DIVS_W      = 15;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 10;

	localparam logic [DIVS_W-1:0] DF_BLOCK    = 15'd17982;
	localparam logic [DIVD_W-1:0] DF_ADD      = 32'd18;
	localparam logic [DIVS_W-1:0] SEC_PER_MIN = 15'd60;
	localparam logic [DIVS_W-1:0] HR_PER_DAY  = 15'd24;

	// reciprocals: ceil(2^shift / divisor), exact over the operand ranges used
	localparam logic [31:0] DF_BLK_RECIP = 32'd3913287965;
	localparam int unsigned DF_BLK_SHIFT = 46;
	localparam logic [15:0] DF_MIN_RECIP = 16'd37325;
	localparam int unsigned DF_MIN_SHIFT = 26;
	localparam logic [31:0] SEC_RECIP    = 32'h8888_8889;
	localparam int unsigned SEC_SHIFT    = 37;
	localparam logic [31:0] DAY_RECIP    = 32'hAAAA_AAAB;
	localparam int unsigned DAY_SHIFT    = 36;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RASTER_625   = 3'd0,
		REG_FIRST_LINE   = 3'd1,
		REG_SECOND_LINE  = 3'd2,
		REG_FPS          = 3'd3,
		REG_DROP_FRAME   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic             raster_625;
		logic [LINE_W-1:0] first_field_line;
		logic [LINE_W-1:0] second_field_line;
		logic [FPS_W-1:0]  frames_per_second;
		logic             drop_frame;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] frame_count;
		logic [LINE_W-1:0]  line_number;
	} item_t;

	typedef struct packed {
		logic [63:0] code_low;
		logic [25:0] code_high;
		logic [31:0] timecode_word;
		logic [7:0]  check_byte;
	} result_t;

	typedef struct packed {
		logic [COUNT_W-1:0] frame_count;
		logic               field;
	} qitem_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quo;
		logic [DIVS_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DROP_BLK,
		S_DROP_MIN,
		S_FRAMES,
		S_SECONDS,
		S_MINUTES,
		S_HOURS,
		S_PACK
	} back_state_t;

	// split a value below 64 into {tens, units}
	function automatic logic [6:0] bcd_split(input logic [5:0] v);
		logic [2:0] tens;
		logic [5:0] units;
		if (v >= 6'd60) tens = 3'd6;
		else if (v >= 6'd50) tens = 3'd5;
		else if (v >= 6'd40) tens = 3'd4;
		else if (v >= 6'd30) tens = 3'd3;
		else if (v >= 6'd20) tens = 3'd2;
		else if (v >= 6'd10) tens = 3'd1;
		else tens = 3'd0;
		units = v - 6'(tens * 4'd10);
		return {tens, units[3:0]};
	endfunction

endpackage

`default_nettype wire

### rtl/core/vitc_queue.sv
//------------------------------------------------------------------------------
// vitc_queue
// Small FIFO between the classifying front end and the conversion back end.
//------------------------------------------------------------------------------
`default_nettype none

module vitc_queue
	import vitc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire qitem_t push_item,
	input  wire logic   pop,
	output logic        full,
	output logic        not_empty,
	output qitem_t      head
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	qitem_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/vitc_front.sv
//------------------------------------------------------------------------------
// vitc_front
// Accepts items, keeps only the four VITC lines and tags each with its field.
//------------------------------------------------------------------------------
`default_nettype none

module vitc_front
	import vitc_pkg::*;
(
	input  wire logic  accept,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output logic       push,
	output qitem_t     push_item
);

	logic [LINE_W:0] line_x;
	logic            hit;

	// compare line + 2 without wrap
	always_comb begin
		line_x = {1'b0, item.line_number};
		hit = (item.line_number == cfg.first_field_line)
		   || (line_x == {1'b0, cfg.first_field_line} + (LINE_W+1)'(2))
		   || (item.line_number == cfg.second_field_line)
		   || (line_x == {1'b0, cfg.second_field_line} + (LINE_W+1)'(2));
		push = accept && hit;
		push_item.frame_count = item.frame_count;
		push_item.field       = (item.line_number >= cfg.second_field_line);
	end

endmodule

`default_nettype wire

### rtl/core/vitc_div.sv
//------------------------------------------------------------------------------
// vitc_div
// Bit-serial restoring divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module vitc_div
	import vitc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int unsigned CNT_W = $clog2(DIVD_W);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W:0]   trial;
	logic              fits;

	always_comb begin
		trial = {rem_q, quo_q[DIVD_W-1]};
		fits  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], fits};
			rem_q <= fits ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIVD_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

### rtl/core/vitc_back.sv
//------------------------------------------------------------------------------
// vitc_back
// Converts a queued count to BCD timecode and packs the 90-bit code word.
//------------------------------------------------------------------------------
`default_nettype none

module vitc_back
	import vitc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   q_valid,
	input  wire qitem_t q_item,
	output logic        pop,
	output div_req_t    div_req,
	input  wire div_rsp_t div_rsp,
	output logic        result_valid,
	output result_t     result
);

	back_state_t       state_q, state_d;
	logic [DIVD_W-1:0] n_q;
	logic              field_q;
	logic [16:0]       blk_q;
	logic [DIVS_W-1:0] m_q;
	logic [DIVD_W-1:0] x_q;
	logic [26:0]       sq_q;
	logic [20:0]       mq_q;
	logic [16:0]       hq_q;
	logic [4:0]        fr_q;
	logic [5:0]        sec_q;
	logic [5:0]        min_q;
	logic              valid_q;
	result_t           result_q;

	logic [DIVS_W-1:0] fps;
	logic [DIVD_W-1:0] n_load;
	logic [63:0]       blk_prod;
	logic [DIVD_W-1:0] blk_rem;
	logic [DIVD_W-1:0] n_blk;
	logic [DIVS_W-1:0] m_adj;
	logic [31:0]       min_prod;
	logic [3:0]        drop_min;
	logic [DIVD_W-1:0] n_drop;
	logic [63:0]       sq_prod;
	logic [63:0]       mq_prod;
	logic [63:0]       hq_prod;
	logic [DIVD_W-1:0] sec_rem;
	logic [26:0]       min_rem;
	logic [20:0]       hr_rem;
	logic              done_out;

	logic [6:0]  fr_bcd, sec_bcd, min_bcd, hr_bcd;
	logic [31:0] tc;
	logic [89:0] word;
	logic [7:0]  xsum;
	logic [7:0]  chk;

	always_comb begin
		fps      = (cfg.frames_per_second == '0) ? DIVS_W'(1) : DIVS_W'(cfg.frames_per_second);
		n_load   = {1'b0, q_item.frame_count};
		blk_prod = 64'(n_load) * 64'(DF_BLK_RECIP);
		blk_rem  = n_q - DIVD_W'(blk_q) * DIVD_W'(DF_BLOCK);
		n_blk    = n_q + DIVD_W'(blk_q) * DF_ADD;
		m_adj    = m_q - DIVS_W'(2);
		min_prod = 32'(m_adj) * 32'(DF_MIN_RECIP);
		// no minute correction in the first two frames of a block
		drop_min = (m_q >= DIVS_W'(2)) ? min_prod[DF_MIN_SHIFT +: 4] : 4'd0;
		n_drop   = n_q + DIVD_W'({drop_min, 1'b0});
		sq_prod  = 64'(x_q) * 64'(SEC_RECIP);
		mq_prod  = 64'(sq_q) * 64'(SEC_RECIP);
		hq_prod  = 64'(mq_q) * 64'(DAY_RECIP);
		sec_rem  = x_q - DIVD_W'(sq_q) * DIVD_W'(SEC_PER_MIN);
		min_rem  = sq_q - 27'(mq_q) * 27'(SEC_PER_MIN);
		hr_rem   = mq_q - 21'(hq_q) * 21'(HR_PER_DAY);
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		div_req  = '0;
		done_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					if (cfg.drop_frame) begin
						state_d = S_DROP_BLK;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = n_load;
						div_req.divisor  = fps;
						state_d = S_FRAMES;
					end
				end
			end
			S_DROP_BLK: begin
				state_d = S_DROP_MIN;
			end
			S_DROP_MIN: begin
				div_req.start    = 1'b1;
				div_req.dividend = n_drop;
				div_req.divisor  = fps;
				state_d = S_FRAMES;
			end
			S_FRAMES: begin
				if (div_rsp.done) begin
					state_d = S_SECONDS;
				end
			end
			S_SECONDS: begin
				state_d = S_MINUTES;
			end
			S_MINUTES: begin
				state_d = S_HOURS;
			end
			S_HOURS: begin
				state_d = S_PACK;
			end
			S_PACK: begin
				done_out = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		fr_bcd  = bcd_split({1'b0, fr_q});
		sec_bcd = bcd_split(sec_q);
		min_bcd = bcd_split(min_q);
		hr_bcd  = bcd_split({1'b0, hr_rem[4:0]});
		tc = {cfg.raster_625 & field_q, 1'b0, hr_bcd[5:4], hr_bcd[3:0],
		      1'b0, min_bcd[6:4], min_bcd[3:0],
		      ~cfg.raster_625 & field_q, sec_bcd[6:4], sec_bcd[3:0],
		      1'b0, cfg.drop_frame, fr_bcd[5:4], fr_bcd[3:0]};
		word = '0;
		for (int i = 0; i < 8; i++) begin
			word[10*i +: 10] = {4'b0000, tc[4*i +: 4], 2'b01};
		end
		word[81:80] = 2'b01;
		xsum = '0;
		for (int b = 0; b < 11; b++) begin
			xsum = xsum ^ word[8*b +: 8];
		end
		chk = {xsum[1:0], xsum[7:2]};
		word[89:82] = chk;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				n_q     <= n_load;
				field_q <= q_item.field;
				blk_q   <= blk_prod[DF_BLK_SHIFT +: 17];
			end
			S_DROP_BLK: begin
				n_q <= n_blk;
				m_q <= blk_rem[DIVS_W-1:0];
			end
			S_DROP_MIN: ;
			S_FRAMES: begin
				if (div_rsp.done) begin
					fr_q <= div_rsp.rem[4:0];
					x_q  <= div_rsp.quo;
				end
			end
			S_SECONDS: begin
				sq_q <= sq_prod[SEC_SHIFT +: 27];
			end
			S_MINUTES: begin
				sec_q <= sec_rem[5:0];
				mq_q  <= mq_prod[SEC_SHIFT +: 21];
			end
			S_HOURS: begin
				min_q <= min_rem[5:0];
				hq_q  <= hq_prod[DAY_SHIFT +: 17];
			end
			S_PACK: begin
				result_q.code_low      <= word[63:0];
				result_q.code_high     <= word[89:64];
				result_q.timecode_word <= tc;
				result_q.check_byte    <= chk;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= done_out;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

### rtl/core/vitc_code_word_generator_unit.sv
// A line on one of the four VITC lines is queued and then strobed as a code word, after
// block and minute correction states when drop-frame is on; other lines give no result.
// The back end converts one code word at a time around a bit-serial frame-rate divide;
// a 2-entry queue takes lines while it works.
// Reset clears the queue and control state and loads the default registers.
// Results are strobed for one cycle; the receiver cannot stall.
//------------------------------------------------------------------------------
// vitc_code_word_generator_unit
// VITC code word generator: line filter, queue, BCD conversion and packing.
//------------------------------------------------------------------------------
`default_nettype none

module vitc_code_word_generator_unit
	import vitc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire item_t                 item,
	output logic                       result_valid,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t     cfg_q;
	logic     push;
	qitem_t   push_item;
	logic     q_full;
	logic     q_valid;
	qitem_t   q_head;
	logic     pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;
	assign busy      = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raster_625        <= 1'b1;
			cfg_q.first_field_line  <= LINE_W'(19);
			cfg_q.second_field_line <= LINE_W'(332);
			cfg_q.frames_per_second <= FPS_W'(25);
			cfg_q.drop_frame        <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RASTER_625:  cfg_q.raster_625        <= cfg_data[0];
				REG_FIRST_LINE:  cfg_q.first_field_line  <= cfg_data[LINE_W-1:0];
				REG_SECOND_LINE: cfg_q.second_field_line <= cfg_data[LINE_W-1:0];
				REG_FPS:         cfg_q.frames_per_second <= cfg_data[FPS_W-1:0];
				REG_DROP_FRAME:  cfg_q.drop_frame        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	vitc_front u_front (
		.accept    (start && !busy),
		.item      (item),
		.cfg       (cfg_q),
		.push      (push),
		.push_item (push_item)
	);

	vitc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	vitc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	vitc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_head),
		.pop          (pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

### rtl/core/vitc_checker.sv
//------------------------------------------------------------------------------
// vitc_checker
// Port-level checks on the code word layout and result spacing.
//------------------------------------------------------------------------------
`default_nettype none

module vitc_checker
	import vitc_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    result_valid,
	input wire result_t result
);

	a_first_sync: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.code_low[1:0] == 2'b01))
		else $error("first sync pair wrong");

	a_last_sync: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.code_high[17:16] == 2'b01))
		else $error("final sync pair wrong");

	a_check_place: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.code_high[25:18] == result.check_byte))
		else $error("check byte not in code word");

	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("results in adjacent cycles");

endmodule

bind vitc_code_word_generator_unit vitc_checker u_vitc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
